// File: rtl/tod_tint_pkg.sv
// Package for the time-of-day palette tint block.
// Holds the RGB555 type, the day stage enum, register indexes and the filter tables.
// Used by every module of the block; depends on nothing else.
package tod_tint_pkg;

	typedef struct packed {
		logic [4:0] b;
		logic [4:0] g;
		logic [4:0] r;
	} rgb555_t;

	typedef enum logic [2:0] {
		STG_MIDNIGHT,
		STG_DAWN,
		STG_DAY,
		STG_SUNSET,
		STG_NIGHTFALL,
		STG_NIGHT
	} day_stage_t;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_HOUR_NOW        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MINUTE_NOW      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAWN_START      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MORNING_START   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUNSET_START    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NIGHTFALL_START = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NIGHT_START     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_MASK    = 3'd7;

	localparam logic [4:0] SPRITE_FIRST = 5'd16;
	localparam logic [4:0] TABLE_LAST   = 5'd29;
	localparam logic [4:0] CHAN_MAX     = 5'd31;

	function automatic rgb555_t rgb(input int r, input int g, input int b);
		rgb555_t c;
		c.r = 5'(r);
		c.g = 5'(g);
		c.b = 5'(b);
		return c;
	endfunction

	localparam rgb555_t DAY_FILTER   = rgb(0, 0, 0);
	localparam rgb555_t NIGHT_FILTER = rgb(14, 14, 6);

	localparam rgb555_t MIDNIGHT_TAB [8] = '{
		rgb(14,14,6), rgb(14,14,7), rgb(14,14,8), rgb(15,15,8),
		rgb(15,15,9), rgb(15,15,9), rgb(16,16,9), rgb(16,16,10)
	};

	localparam rgb555_t DAWN_TAB [30] = '{
		rgb(15,15,10), rgb(15,15,10), rgb(14,14,10), rgb(13,13,10), rgb(12,12,10),
		rgb(11,11,10), rgb(10,10,10), rgb(9,9,10), rgb(8,8,10), rgb(8,8,11),
		rgb(7,7,11), rgb(6,6,11), rgb(5,5,11), rgb(4,4,11), rgb(3,3,11),
		rgb(2,2,11), rgb(1,1,11), rgb(0,0,11), rgb(0,0,10), rgb(0,0,9),
		rgb(0,0,8), rgb(0,0,7), rgb(0,0,6), rgb(0,0,5), rgb(0,0,4),
		rgb(0,0,3), rgb(0,0,2), rgb(0,0,1), rgb(0,0,0), rgb(0,0,0)
	};

	localparam rgb555_t SUNSET_TAB [30] = '{
		rgb(0,0,1), rgb(0,1,1), rgb(0,1,2), rgb(0,1,3), rgb(0,2,3),
		rgb(0,2,4), rgb(0,2,5), rgb(0,3,5), rgb(0,3,6), rgb(0,3,7),
		rgb(0,4,7), rgb(0,4,8), rgb(0,4,9), rgb(0,5,9), rgb(0,5,10),
		rgb(0,5,11), rgb(0,6,11), rgb(0,6,12), rgb(0,6,13), rgb(0,7,13),
		rgb(0,7,14), rgb(0,7,14), rgb(0,8,14), rgb(0,9,14), rgb(0,10,14),
		rgb(0,11,14), rgb(0,12,14), rgb(0,13,14), rgb(0,14,14), rgb(0,14,14)
	};

	localparam rgb555_t NIGHTFALL_TAB [30] = '{
		rgb(0,14,14), rgb(0,14,14), rgb(0,14,13), rgb(0,14,12), rgb(0,14,11),
		rgb(0,14,10), rgb(1,14,10), rgb(1,14,9), rgb(0,14,8), rgb(1,14,7),
		rgb(1,14,6), rgb(2,14,6), rgb(2,14,5), rgb(2,14,4), rgb(2,14,3),
		rgb(2,14,2), rgb(2,14,2), rgb(3,14,3), rgb(4,14,4), rgb(5,14,5),
		rgb(6,14,6), rgb(7,14,6), rgb(8,14,6), rgb(9,14,6), rgb(10,14,6),
		rgb(11,14,6), rgb(12,14,6), rgb(13,14,6), rgb(14,14,6), rgb(14,14,6)
	};

endpackage

// File: rtl/tod_tint_cfg.sv
// Configuration registers and filter colour selection for the palette tint.
// Decodes the day stage from the hour and looks the filter up in the package tables.
// Depends on tod_tint_pkg.
module tod_tint_cfg #(
	parameter int PALETTE_COUNT = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [tod_tint_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tod_tint_pkg::CFG_DATA_W-1:0] cfg_data,
	output tod_tint_pkg::rgb555_t             filter,
	output logic [PALETTE_COUNT-1:0]          palette_mask
);
	import tod_tint_pkg::*;

	logic [4:0] hour_q;
	logic [5:0] minute_q;
	logic [4:0] dawn_q;
	logic [4:0] morning_q;
	logic [4:0] sunset_q;
	logic [4:0] nightfall_q;
	logic [4:0] night_q;
	logic [PALETTE_COUNT-1:0] mask_q;
	rgb555_t filter_q;

	day_stage_t stage;
	logic [4:0] half_idx;
	logic [2:0] eighth_idx;
	rgb555_t filter_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q      <= 5'd12;
			minute_q    <= 6'd0;
			dawn_q      <= 5'd4;
			morning_q   <= 5'd6;
			sunset_q    <= 5'd17;
			nightfall_q <= 5'd19;
			night_q     <= 5'd22;
			mask_q      <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HOUR_NOW:        hour_q      <= cfg_data[4:0];
				REG_MINUTE_NOW:      minute_q    <= cfg_data[5:0];
				REG_DAWN_START:      dawn_q      <= cfg_data[4:0];
				REG_MORNING_START:   morning_q   <= cfg_data[4:0];
				REG_SUNSET_START:    sunset_q    <= cfg_data[4:0];
				REG_NIGHTFALL_START: nightfall_q <= cfg_data[4:0];
				REG_NIGHT_START:     night_q     <= cfg_data[4:0];
				REG_PALETTE_MASK:    mask_q      <= cfg_data[PALETTE_COUNT-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (hour_q < dawn_q)
			stage = STG_MIDNIGHT;
		else if (hour_q < morning_q)
			stage = STG_DAWN;
		else if (hour_q < sunset_q)
			stage = STG_DAY;
		else if (hour_q < nightfall_q)
			stage = STG_SUNSET;
		else if (hour_q < night_q)
			stage = STG_NIGHTFALL;
		else
			stage = STG_NIGHT;
	end

	// table entry saturates at the last one for minutes past the table
	assign half_idx   = (minute_q[5:1] > TABLE_LAST) ? TABLE_LAST : minute_q[5:1];
	assign eighth_idx = (hour_q == 5'd0) ? minute_q[5:3] : 3'd7;

	always_comb begin
		unique case (stage)
			STG_MIDNIGHT:  filter_d = MIDNIGHT_TAB[eighth_idx];
			STG_DAWN:      filter_d = DAWN_TAB[half_idx];
			STG_DAY:       filter_d = DAY_FILTER;
			STG_SUNSET:    filter_d = SUNSET_TAB[half_idx];
			STG_NIGHTFALL: filter_d = NIGHTFALL_TAB[half_idx];
			STG_NIGHT:     filter_d = NIGHT_FILTER;
			default:       filter_d = DAY_FILTER;
		endcase
	end

	// filter at reset matches the reset hour, which falls in the day stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			filter_q <= DAY_FILTER;
		else
			filter_q <= filter_d;
	end

	assign filter       = filter_q;
	assign palette_mask = mask_q;

endmodule

// File: rtl/tod_tint_pipe.sv
// Four-stage tint datapath: enable check, filter invert, channel multiply, scale and pack.
// Each stage holds its own valid bit and advances when the stage after it has room.
// Depends on tod_tint_pkg.
module tod_tint_pipe #(
	parameter int PALETTE_COUNT = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [4:0]            palette_number,
	input  logic [14:0]           colour_in,
	input  logic                  tag_exempt,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [14:0]           colour_out,
	input  tod_tint_pkg::rgb555_t filter,
	input  logic [PALETTE_COUNT-1:0] palette_mask
);
	import tod_tint_pkg::*;

	localparam int PAL_IDX_W = (PALETTE_COUNT > 1) ? $clog2(PALETTE_COUNT) : 1;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic    apply_d;
	logic    apply_s1, apply_s2, apply_s3;
	rgb555_t col_s1, col_s2, col_s3;
	rgb555_t inv_s2;
	logic [9:0] prod_r_s3, prod_g_s3, prod_b_s3;
	logic [14:0] col_s4;

	logic [5:0] sh_r, sh_g, sh_b;
	rgb555_t tinted;

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		apply_d = ({1'b0, palette_number} < 6'(PALETTE_COUNT))
		       && palette_mask[palette_number[PAL_IDX_W-1:0]]
		       && ((palette_number < SPRITE_FIRST) || !tag_exempt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			apply_s1 <= apply_d;
			col_s1   <= colour_in;
		end
		if (rdy_s2 && v_s1) begin
			apply_s2 <= apply_s1;
			col_s2   <= col_s1;
			inv_s2.r <= CHAN_MAX - filter.r;
			inv_s2.g <= CHAN_MAX - filter.g;
			inv_s2.b <= CHAN_MAX - filter.b;
		end
		if (rdy_s3 && v_s2) begin
			apply_s3  <= apply_s2;
			col_s3    <= col_s2;
			prod_r_s3 <= 10'(col_s2.r) * 10'(inv_s2.r);
			prod_g_s3 <= 10'(col_s2.g) * 10'(inv_s2.g);
			prod_b_s3 <= 10'(col_s2.b) * 10'(inv_s2.b);
		end
		if (rdy_s4 && v_s3)
			col_s4 <= apply_s3 ? tinted : col_s3;
	end

	// drop to zero above full scale; the product never reaches it
	always_comb begin
		sh_r = 6'(prod_r_s3 >> 5);
		sh_g = 6'(prod_g_s3 >> 5);
		sh_b = 6'(prod_b_s3 >> 5);
		tinted.r = (sh_r > 6'(CHAN_MAX)) ? 5'd0 : sh_r[4:0];
		tinted.g = (sh_g > 6'(CHAN_MAX)) ? 5'd0 : sh_g[4:0];
		tinted.b = (sh_b > 6'(CHAN_MAX)) ? 5'd0 : sh_b[4:0];
	end

	assign out_valid  = v_s4;
	assign colour_out = col_s4;

endmodule

// File: rtl/time_of_day_palette_tint_top.sv
// Time-of-day palette tint: applies a daylight filter colour to RGB555 palette entries.
// Instantiates tod_tint_cfg (registers, filter lookup) and tod_tint_pipe (datapath).
// Depends on tod_tint_pkg.
//
// Usage:
//   Input beats carry palette_number, colour_in and tag_exempt on in_valid/in_ready.
//   Result beats carry colour_out on out_valid/out_ready, one per input, in order.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; write it only while no beat is in flight. The filter colour is registered
//   in the cycle after a write. Accepted beats pass through stages s1 to s4 before
//   out_valid; one beat per cycle is sustained while the receiver keeps out_ready
//   high, set by the four-stage pipeline that holds a beat per stage.
//   When the receiver stalls, beats pile up in the stages and in_ready drops only
//   once all four stages hold a beat; nothing is lost or repeated.
//   Reset clears all stage valid bits and loads the register reset values
//   (hour 12, minute 0, stage bounds 4/6/17/19/22, all palettes enabled).
module time_of_day_palette_tint_top #(
	parameter int PALETTE_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  palette_number,
	input  logic [14:0] colour_in,
	input  logic        tag_exempt,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] colour_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [tod_tint_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tod_tint_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tod_tint_pkg::*;

	rgb555_t filter;
	logic [PALETTE_COUNT-1:0] palette_mask;

	assign cfg_ready = 1'b1;

	tod_tint_cfg #(
		.PALETTE_COUNT(PALETTE_COUNT)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.filter       (filter),
		.palette_mask (palette_mask)
	);

	tod_tint_pipe #(
		.PALETTE_COUNT(PALETTE_COUNT)
	) u_pipe (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.palette_number (palette_number),
		.colour_in      (colour_in),
		.tag_exempt     (tag_exempt),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.colour_out     (colour_out),
		.filter         (filter),
		.palette_mask   (palette_mask)
	);

endmodule

// File: test/tb_top.sv
// Testbench for time_of_day_palette_tint_top: random and directed palette beats with
// random idling on both channels, checked against a tint predictor held here.
// Depends on tod_tint_pkg and the RTL of the block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tod_tint_pkg::*;

	localparam int PAL_COUNT = 32;
	localparam int QUIET_LIMIT = 1000;
	localparam int LATENCY_SLACK = 8;

	typedef struct {
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [4:0]  dawn;
		logic [4:0]  morning;
		logic [4:0]  sunset;
		logic [4:0]  nightfall;
		logic [4:0]  night;
		logic [31:0] mask;
	} tint_cfg_t;

	typedef struct {
		logic [4:0]  pal;
		logic [14:0] colour;
		logic        exempt;
		int          gap;
	} pixel_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [4:0]  palette_number = '0;
	logic [14:0] colour_in = '0;
	logic        tag_exempt = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [14:0] colour_out;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pixel_beat_t pixel_q[$];
	logic [14:0] tinted_q[$];
	pixel_beat_t next_beat;
	int          beat_wait = 0;
	int          stall_left = 0;
	int          quiet_cycles = 0;
	int          mismatch_count = 0;
	bit          steady_flow = 1'b0;

	tint_cfg_t tint_regs = '{hour: 5'd12, minute: 6'd0, dawn: 5'd4, morning: 5'd6,
		sunset: 5'd17, nightfall: 5'd19, night: 5'd22, mask: 32'hFFFF_FFFF};

	function automatic rgb555_t rgb_of(input int r, input int g, input int b);
		rgb555_t c;
		c.r = 5'(r);
		c.g = 5'(g);
		c.b = 5'(b);
		return c;
	endfunction

	rgb555_t day_filter = rgb_of(0, 0, 0);
	rgb555_t night_filter = rgb_of(14, 14, 6);

	rgb555_t midnight_filter [8] = '{
		rgb_of(14,14,6), rgb_of(14,14,7), rgb_of(14,14,8), rgb_of(15,15,8),
		rgb_of(15,15,9), rgb_of(15,15,9), rgb_of(16,16,9), rgb_of(16,16,10)
	};

	rgb555_t dawn_filter [30] = '{
		rgb_of(15,15,10), rgb_of(15,15,10), rgb_of(14,14,10), rgb_of(13,13,10),
		rgb_of(12,12,10), rgb_of(11,11,10), rgb_of(10,10,10), rgb_of(9,9,10),
		rgb_of(8,8,10), rgb_of(8,8,11), rgb_of(7,7,11), rgb_of(6,6,11),
		rgb_of(5,5,11), rgb_of(4,4,11), rgb_of(3,3,11), rgb_of(2,2,11),
		rgb_of(1,1,11), rgb_of(0,0,11), rgb_of(0,0,10), rgb_of(0,0,9),
		rgb_of(0,0,8), rgb_of(0,0,7), rgb_of(0,0,6), rgb_of(0,0,5),
		rgb_of(0,0,4), rgb_of(0,0,3), rgb_of(0,0,2), rgb_of(0,0,1),
		rgb_of(0,0,0), rgb_of(0,0,0)
	};

	rgb555_t sunset_filter [30] = '{
		rgb_of(0,0,1), rgb_of(0,1,1), rgb_of(0,1,2), rgb_of(0,1,3),
		rgb_of(0,2,3), rgb_of(0,2,4), rgb_of(0,2,5), rgb_of(0,3,5),
		rgb_of(0,3,6), rgb_of(0,3,7), rgb_of(0,4,7), rgb_of(0,4,8),
		rgb_of(0,4,9), rgb_of(0,5,9), rgb_of(0,5,10), rgb_of(0,5,11),
		rgb_of(0,6,11), rgb_of(0,6,12), rgb_of(0,6,13), rgb_of(0,7,13),
		rgb_of(0,7,14), rgb_of(0,7,14), rgb_of(0,8,14), rgb_of(0,9,14),
		rgb_of(0,10,14), rgb_of(0,11,14), rgb_of(0,12,14), rgb_of(0,13,14),
		rgb_of(0,14,14), rgb_of(0,14,14)
	};

	rgb555_t nightfall_filter [30] = '{
		rgb_of(0,14,14), rgb_of(0,14,14), rgb_of(0,14,13), rgb_of(0,14,12),
		rgb_of(0,14,11), rgb_of(0,14,10), rgb_of(1,14,10), rgb_of(1,14,9),
		rgb_of(0,14,8), rgb_of(1,14,7), rgb_of(1,14,6), rgb_of(2,14,6),
		rgb_of(2,14,5), rgb_of(2,14,4), rgb_of(2,14,3), rgb_of(2,14,2),
		rgb_of(2,14,2), rgb_of(3,14,3), rgb_of(4,14,4), rgb_of(5,14,5),
		rgb_of(6,14,6), rgb_of(7,14,6), rgb_of(8,14,6), rgb_of(9,14,6),
		rgb_of(10,14,6), rgb_of(11,14,6), rgb_of(12,14,6), rgb_of(13,14,6),
		rgb_of(14,14,6), rgb_of(14,14,6)
	};

	time_of_day_palette_tint_top #(
		.PALETTE_COUNT(PAL_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.palette_number(palette_number),
		.colour_in(colour_in),
		.tag_exempt(tag_exempt),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.colour_out(colour_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [4:0] darken(input logic [4:0] chan, input logic [4:0] filt);
		int scaled;
		scaled = (int'(chan) * (int'(CHAN_MAX) - int'(filt))) >>> 5;
		// dead clamp, kept as in the block
		return (scaled > int'(CHAN_MAX)) ? 5'd0 : scaled[4:0];
	endfunction

	function automatic logic [14:0] tint_colour(input logic [4:0] pal, input logic [14:0] raw,
			input logic exempt);
		rgb555_t    c;
		rgb555_t    f;
		rgb555_t    r;
		logic [4:0] half_idx;
		day_stage_t stage;
		c = raw;
		if (int'(pal) >= PAL_COUNT || !tint_regs.mask[pal] || (pal >= SPRITE_FIRST && exempt))
			return raw;
		half_idx = tint_regs.minute[5:1];
		if (half_idx > TABLE_LAST)
			half_idx = TABLE_LAST;
		if (tint_regs.hour < tint_regs.dawn)
			stage = STG_MIDNIGHT;
		else if (tint_regs.hour < tint_regs.morning)
			stage = STG_DAWN;
		else if (tint_regs.hour < tint_regs.sunset)
			stage = STG_DAY;
		else if (tint_regs.hour < tint_regs.nightfall)
			stage = STG_SUNSET;
		else if (tint_regs.hour < tint_regs.night)
			stage = STG_NIGHTFALL;
		else
			stage = STG_NIGHT;
		case (stage)
			STG_MIDNIGHT: f = midnight_filter[(tint_regs.hour == 5'd0) ? tint_regs.minute[5:3] : 3'd7];
			STG_DAWN:      f = dawn_filter[half_idx];
			STG_DAY:       f = day_filter;
			STG_SUNSET:    f = sunset_filter[half_idx];
			STG_NIGHTFALL: f = nightfall_filter[half_idx];
			default:       f = night_filter;
		endcase
		r.r = darken(c.r, f.r);
		r.g = darken(c.g, f.g);
		r.b = darken(c.b, f.b);
		return r;
	endfunction

	function automatic tint_cfg_t settings_of(input int h, input int m, input int d,
			input int mo, input int su, input int nf, input int ni, input logic [31:0] mask);
		tint_cfg_t s;
		s.hour = 5'(h);
		s.minute = 6'(m);
		s.dawn = 5'(d);
		s.morning = 5'(mo);
		s.sunset = 5'(su);
		s.nightfall = 5'(nf);
		s.night = 5'(ni);
		s.mask = mask;
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic queue_pixel(input logic [4:0] pal, input logic [14:0] colour,
			input logic exempt);
		pixel_beat_t b;
		b.pal = pal;
		b.colour = colour;
		b.exempt = exempt;
		b.gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 15);
		pixel_q.push_back(b);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pixel_q.size() != 0 || in_valid || tinted_q.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		logic [31:0] noisy;
		// junk in the unused upper bits must be ignored
		noisy = $urandom;
		case (idx)
			REG_MINUTE_NOW:   noisy[5:0] = value[5:0];
			REG_PALETTE_MASK: noisy = value;
			default:          noisy[4:0] = value[4:0];
		endcase
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= noisy;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_HOUR_NOW:        tint_regs.hour = noisy[4:0];
			REG_MINUTE_NOW:      tint_regs.minute = noisy[5:0];
			REG_DAWN_START:      tint_regs.dawn = noisy[4:0];
			REG_MORNING_START:   tint_regs.morning = noisy[4:0];
			REG_SUNSET_START:    tint_regs.sunset = noisy[4:0];
			REG_NIGHTFALL_START: tint_regs.nightfall = noisy[4:0];
			REG_NIGHT_START:     tint_regs.night = noisy[4:0];
			default:             tint_regs.mask = noisy;
		endcase
	endtask

	task automatic apply_cfg(input tint_cfg_t s, input bit steady);
		wait_drained();
		repeat (LATENCY_SLACK) @(posedge clk);
		write_reg(REG_HOUR_NOW, 32'(s.hour));
		write_reg(REG_MINUTE_NOW, 32'(s.minute));
		write_reg(REG_DAWN_START, 32'(s.dawn));
		write_reg(REG_MORNING_START, 32'(s.morning));
		write_reg(REG_SUNSET_START, 32'(s.sunset));
		write_reg(REG_NIGHTFALL_START, 32'(s.nightfall));
		write_reg(REG_NIGHT_START, 32'(s.night));
		write_reg(REG_PALETTE_MASK, s.mask);
		// filter colour settles in the cycle after the last write
		repeat (2) @(posedge clk);
		steady_flow = steady;
	endtask

	// Input driver: present queued beats, holding each until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			beat_wait = 0;
		end else begin
			if (in_valid && in_ready)
				tinted_q.push_back(tint_colour(palette_number, colour_in, tag_exempt));
			if (!in_valid || in_ready) begin
				if (pixel_q.size() != 0 && beat_wait >= pixel_q[0].gap) begin
					next_beat = pixel_q.pop_front();
					palette_number <= next_beat.pal;
					colour_in <= next_beat.colour;
					tag_exempt <= next_beat.exempt;
					in_valid <= 1'b1;
					beat_wait = 0;
				end else begin
					in_valid <= 1'b0;
					if (pixel_q.size() != 0)
						beat_wait++;
				end
			end
		end
	end

	// Result monitor: check each beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (tinted_q.size() == 0)
					report_mismatch($sformatf("colour_out %h with nothing expected", colour_out));
				else if (colour_out !== tinted_q[0])
					report_mismatch($sformatf("colour_out expected %h got %h",
						tinted_q[0], colour_out));
				if (tinted_q.size() != 0)
					void'(tinted_q.pop_front());
				stall_left = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 15);
			end else if (stall_left != 0) begin
				stall_left--;
			end
			out_ready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		tint_cfg_t s;
		int        phase;
		int        n;
		int        last_hour;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: day stage, zero filter
		queue_pixel(5'd0, 15'h0000, 1'b0);
		queue_pixel(5'd0, 15'h7FFF, 1'b0);
		queue_pixel(5'd15, 15'h7FFF, 1'b1);
		queue_pixel(5'd16, 15'h7FFF, 1'b1);
		queue_pixel(5'd16, 15'h7FFF, 1'b0);
		queue_pixel(5'd31, 15'h7FFF, 1'b1);
		queue_pixel(5'd31, 15'h5555, 1'b0);

		// midnight at hour zero with a minute past 59
		apply_cfg(settings_of(0, 63, 4, 6, 17, 19, 22, '1), 1'b0);
		queue_pixel(5'd3, 15'h7FFF, 1'b0);
		queue_pixel(5'd20, 15'h2AAA, 1'b0);
		// midnight at a later hour uses the last entry
		apply_cfg(settings_of(3, 17, 4, 6, 17, 19, 22, '1), 1'b0);
		queue_pixel(5'd7, 15'h7FFF, 1'b0);
		// dawn with the table index saturated
		apply_cfg(settings_of(5, 63, 4, 6, 17, 19, 22, '1), 1'b0);
		queue_pixel(5'd9, 15'h7FFF, 1'b0);
		queue_pixel(5'd24, 15'h7FFF, 1'b1);
		apply_cfg(settings_of(18, 59, 4, 6, 17, 19, 22, '1), 1'b0);
		queue_pixel(5'd1, 15'h7FFF, 1'b0);
		apply_cfg(settings_of(20, 0, 4, 6, 17, 19, 22, '1), 1'b0);
		queue_pixel(5'd30, 15'h7FFF, 1'b0);
		apply_cfg(settings_of(23, 30, 4, 6, 17, 19, 22, '1), 1'b0);
		queue_pixel(5'd2, 15'h7FFF, 1'b0);
		// hour past 23 against a night bound of 24
		apply_cfg(settings_of(24, 1, 4, 6, 17, 19, 24, '1), 1'b0);
		queue_pixel(5'd12, 15'h7FFF, 1'b0);
		// unordered stage bounds
		apply_cfg(settings_of(15, 40, 20, 2, 10, 5, 3, '1), 1'b0);
		queue_pixel(5'd4, 15'h7FFF, 1'b0);
		apply_cfg(settings_of(12, 0, 4, 6, 17, 19, 22, 32'hAAAA_AAAA), 1'b0);
		queue_pixel(5'd0, 15'h7FFF, 1'b0);
		queue_pixel(5'd1, 15'h7FFF, 1'b0);
		apply_cfg(settings_of(31, 63, 31, 31, 31, 31, 31, '1), 1'b0);
		queue_pixel(5'd31, 15'h7FFF, 1'b0);
		apply_cfg(settings_of(0, 0, 0, 0, 0, 0, 0, '0), 1'b0);
		queue_pixel(5'd0, 15'h7FFF, 1'b0);

		for (phase = 0; phase < 40; phase++) begin
			if ($urandom_range(0, 9) < 7) begin
				s.dawn = 5'($urandom_range(0, 6));
				s.morning = s.dawn + 5'($urandom_range(0, 4));
				s.sunset = s.morning + 5'($urandom_range(0, 12));
				s.nightfall = s.sunset + 5'($urandom_range(0, 3));
				last_hour = int'(s.nightfall) + $urandom_range(0, 5);
				s.night = (last_hour > 24) ? 5'd24 : 5'(last_hour);
				s.hour = ($urandom_range(0, 5) == 0) ? 5'd0 : 5'($urandom_range(0, 23));
				s.minute = 6'($urandom_range(0, 59));
			end else begin
				s.dawn = 5'($urandom);
				s.morning = 5'($urandom);
				s.sunset = 5'($urandom);
				s.nightfall = 5'($urandom);
				s.night = 5'($urandom);
				s.hour = 5'($urandom);
				s.minute = 6'($urandom);
			end
			case ($urandom_range(0, 7))
				0:       s.mask = '0;
				1, 2:    s.mask = '1;
				default: s.mask = $urandom;
			endcase
			apply_cfg(s, $urandom_range(0, 3) == 0);
			for (n = 0; n < 20; n++)
				queue_pixel(5'($urandom_range(0, 31)),
					($urandom_range(0, 7) == 0) ? {15{1'($urandom)}} : 15'($urandom),
					1'($urandom));
		end

		wait_drained();
		repeat (LATENCY_SLACK) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
